// ===== src/sbcd_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sbcd_pkg: shuffle bag card deck shared definitions
// Item types, op and register codes, sequencer states, generator constants.
// ----------------------------------------------------------------------------
package sbcd_pkg;

  localparam int DECK_DEPTH_DEF = 256;
  localparam int DEF_DECK_SIZE  = 256;
  localparam logic [31:0] DEF_SEED = 32'd1;

  localparam int CFG_DATA_W = 32;
  localparam int CFG_IDX_W  = 1;

  localparam logic [31:0] LCG_MUL = 32'd1103515245;
  localparam logic [31:0] LCG_INC = 32'd12345;
  localparam int RAND_W  = 15;
  localparam int RAND_LO = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DECK_SIZE = 1'b0,
    REG_SEED      = 1'b1
  } cfg_reg_t;

  typedef enum logic [1:0] {
    OP_ADD     = 2'd0,
    OP_SHUFFLE = 2'd1,
    OP_DRAW    = 2'd2,
    OP_CLEAR   = 2'd3
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [7:0] card;
    logic [8:0] count;
  } cmd_t;

  typedef struct packed {
    logic [7:0] drawn_card;
    logic       status;
    logic       reshuffled;
    logic [8:0] fill_level;
  } rsp_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_ADD,
    S_RNG,
    S_MOD,
    S_RD_I,
    S_RD_J,
    S_WR_I,
    S_WR_J,
    S_DRAW_RD,
    S_DRAW_CAP,
    S_DONE
  } state_t;

endpackage : sbcd_pkg
`default_nettype wire

// ===== src/shuffle_bag_card_deck_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// shuffle_bag_card_deck_core: card deck with add, shuffle, draw and clear
// One card store, one position pointer, LCG-driven Fisher-Yates style swaps.
// ----------------------------------------------------------------------------
// Channel  Signals                        Direction  Meaning
// cmd      cmd_valid, cmd_stall, cmd      in         op, card, count
// rsp      rsp_valid, rsp_stall, rsp      out        drawn_card, status, ...
// cfg      cfg_we, cfg_index, cfg_data    in         deck_size, seed
//
// One item at a time. Add: writes card at position until count runs out or
// the deck is full. Draw: read, capture. Shuffle, per live entry: LCG
// multiply, 15-step remainder, read, read, write, write on the single store
// port. A draw that empties the deck adds a full shuffle. Clear: zeroing
// sweep. After reset and after each deck_size write the store is swept to
// zero with cmd_stall high. The result sits in an output register; cmd is
// taken again as soon as that register has been loaded.
module shuffle_bag_card_deck_core #(
  parameter int DECK_DEPTH = sbcd_pkg::DECK_DEPTH_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            cfg_we,
  input  wire logic [sbcd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [sbcd_pkg::CFG_DATA_W-1:0] cfg_data,
  input  wire logic                            cmd_valid,
  output logic                                 cmd_stall,
  input  wire sbcd_pkg::cmd_t                  cmd,
  output logic                                 rsp_valid,
  input  wire logic                            rsp_stall,
  output sbcd_pkg::rsp_t                       rsp
);
  import sbcd_pkg::*;

  localparam int AW  = $clog2(DECK_DEPTH);
  localparam int SZW = $clog2(DECK_DEPTH + 1);
  localparam int PW  = (SZW > 9) ? SZW : 9;
  localparam int BCW = $clog2(RAND_W);
  localparam int RESET_LIVE = (DECK_DEPTH < DEF_DECK_SIZE) ? DECK_DEPTH : DEF_DECK_SIZE;

  state_t state, state_next;

  logic [SZW-1:0]    position, position_next;
  logic [SZW-1:0]    live_size, live_size_next;
  logic [31:0]       rng, rng_next;
  logic [SZW-1:0]    idx, idx_next;
  logic [AW-1:0]     jdx, jdx_next;
  logic [SZW-1:0]    rem, rem_next;
  logic [RAND_W-1:0] rv, rv_next;
  logic [BCW-1:0]    bitcnt, bitcnt_next;
  logic [8:0]        cnt, cnt_next;
  logic [7:0]        card_q, card_q_next;
  logic [7:0]        hold_d, hold_d_next;
  logic [7:0]        drawn, drawn_next;
  logic              status, status_next;
  logic              resh, resh_next;
  logic              pend, pend_next;
  logic              rsp_valid_next;
  rsp_t              rsp_next;

  logic [7:0]        mem [DECK_DEPTH];
  logic [7:0]        rdata;
  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  logic [7:0]        mem_wdata;
  logic [AW-1:0]     mem_raddr;

  logic [31:0]       rng_mul;
  logic [SZW:0]      trial;
  logic              trial_ge;
  logic [SZW-1:0]    rem_step;
  logic [SZW-1:0]    pos_inc;
  logic [SZW-1:0]    idx_inc;
  logic [31:0]       ds_w;
  logic [SZW-1:0]    ds_clamped;
  logic [PW-1:0]     pos_wide;
  logic              rsp_free;

  assign rng_mul    = rng * LCG_MUL + LCG_INC;
  assign trial      = {rem, rv[RAND_W-1]};
  assign trial_ge   = trial >= {1'b0, live_size};
  assign rem_step   = trial_ge ? SZW'(trial - {1'b0, live_size}) : trial[SZW-1:0];
  assign pos_inc    = position + SZW'(1);
  assign idx_inc    = idx + SZW'(1);
  assign ds_w       = {23'd0, cfg_data[8:0]};
  assign ds_clamped = (ds_w > 32'(DECK_DEPTH)) ? SZW'(DECK_DEPTH) : SZW'(ds_w);
  assign pos_wide   = PW'(position);
  assign rsp_free   = !rsp_valid || !rsp_stall;
  assign cmd_stall  = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rdata <= mem[mem_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next     = state;
    position_next  = position;
    live_size_next = live_size;
    rng_next       = rng;
    idx_next       = idx;
    jdx_next       = jdx;
    rem_next       = rem;
    rv_next        = rv;
    bitcnt_next    = bitcnt;
    cnt_next       = cnt;
    card_q_next    = card_q;
    hold_d_next    = hold_d;
    drawn_next     = drawn;
    status_next    = status;
    resh_next      = resh;
    pend_next      = pend;
    rsp_valid_next = rsp_valid && rsp_stall;
    rsp_next       = rsp;
    mem_we         = 1'b0;
    mem_waddr      = idx[AW-1:0];
    mem_wdata      = 8'd0;
    mem_raddr      = idx[AW-1:0];

    unique case (state)
      S_CLEAR: begin
        mem_we = 1'b1;
        if (idx == SZW'(DECK_DEPTH - 1)) begin
          state_next = pend ? S_DONE : S_IDLE;
        end else begin
          idx_next = idx_inc;
        end
      end
      S_IDLE: begin
        if (cmd_valid) begin
          pend_next   = 1'b1;
          status_next = 1'b0;
          resh_next   = 1'b0;
          drawn_next  = 8'd0;
          card_q_next = cmd.card;
          cnt_next    = cmd.count;
          unique case (cmd.op)
            OP_ADD: begin
              state_next = S_ADD;
            end
            OP_SHUFFLE: begin
              if (live_size == '0) begin
                status_next = 1'b1;
                state_next  = S_DONE;
              end else begin
                idx_next   = '0;
                state_next = S_RNG;
              end
            end
            OP_DRAW: begin
              if (live_size == '0 || position >= live_size) begin
                status_next = 1'b1;
                state_next  = S_DONE;
              end else begin
                state_next = S_DRAW_RD;
              end
            end
            OP_CLEAR: begin
              idx_next       = '0;
              live_size_next = '0;
              position_next  = '0;
              state_next     = S_CLEAR;
            end
          endcase
        end
      end
      S_ADD: begin
        if (cnt != 9'd0 && position < live_size) begin
          mem_we        = 1'b1;
          mem_waddr     = position[AW-1:0];
          mem_wdata     = card_q;
          position_next = pos_inc;
          cnt_next      = cnt - 9'd1;
        end else begin
          state_next = S_DONE;
        end
      end
      S_RNG: begin
        rng_next    = rng_mul;
        rv_next     = rng_mul[RAND_LO +: RAND_W];
        rem_next    = '0;
        bitcnt_next = '0;
        state_next  = S_MOD;
      end
      S_MOD: begin
        rem_next    = rem_step;
        rv_next     = {rv[RAND_W-2:0], 1'b0};
        bitcnt_next = bitcnt + BCW'(1);
        if (bitcnt == BCW'(RAND_W - 1)) begin
          jdx_next   = rem_step[AW-1:0];
          state_next = S_RD_I;
        end
      end
      S_RD_I: begin
        mem_raddr  = idx[AW-1:0];
        state_next = S_RD_J;
      end
      S_RD_J: begin
        mem_raddr   = jdx;
        hold_d_next = rdata;
        state_next  = S_WR_I;
      end
      S_WR_I: begin
        mem_we     = 1'b1;
        mem_waddr  = idx[AW-1:0];
        mem_wdata  = rdata;
        state_next = S_WR_J;
      end
      S_WR_J: begin
        mem_we    = 1'b1;
        mem_waddr = jdx;
        mem_wdata = hold_d;
        if (idx_inc >= live_size) begin
          position_next = '0;
          state_next    = S_DONE;
        end else begin
          idx_next   = idx_inc;
          state_next = S_RNG;
        end
      end
      S_DRAW_RD: begin
        mem_raddr  = position[AW-1:0];
        state_next = S_DRAW_CAP;
      end
      S_DRAW_CAP: begin
        drawn_next    = rdata;
        position_next = pos_inc;
        if (pos_inc >= live_size) begin
          resh_next  = 1'b1;
          idx_next   = '0;
          state_next = S_RNG;
        end else begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (rsp_free) begin
          rsp_next.drawn_card = drawn;
          rsp_next.status     = status;
          rsp_next.reshuffled = resh;
          rsp_next.fill_level = pos_wide[8:0];
          rsp_valid_next      = 1'b1;
          pend_next           = 1'b0;
          state_next          = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase

    if (cfg_we) begin
      if (cfg_index == REG_DECK_SIZE) begin
        live_size_next = ds_clamped;
        position_next  = '0;
        idx_next       = '0;
        state_next     = S_CLEAR;
      end else begin
        rng_next = cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      position  <= '0;
      live_size <= SZW'(RESET_LIVE);
      rng       <= DEF_SEED;
      idx       <= '0;
      pend      <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      position  <= position_next;
      live_size <= live_size_next;
      rng       <= rng_next;
      idx       <= idx_next;
      pend      <= pend_next;
      rsp_valid <= rsp_valid_next;
    end
    jdx    <= jdx_next;
    rem    <= rem_next;
    rv     <= rv_next;
    bitcnt <= bitcnt_next;
    cnt    <= cnt_next;
    card_q <= card_q_next;
    hold_d <= hold_d_next;
    drawn  <= drawn_next;
    status <= status_next;
    resh   <= resh_next;
    rsp    <= rsp_next;
  end

  a_pos_in_range: assert property (@(posedge clk) disable iff (rst)
    position <= live_size && pos_wide <= PW'(DECK_DEPTH))
    else $error("position beyond live size");

  a_done_has_item: assert property (@(posedge clk) disable iff (rst)
    state == S_DONE |-> pend)
    else $error("result without an accepted item");

  a_resh_ok: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.reshuffled |-> !rsp.status && rsp.fill_level == 9'd0)
    else $error("reshuffle with bad status or position");

endmodule : shuffle_bag_card_deck_core
`default_nettype wire
